/* hw/rtl/shbm_pkg.sv */
package shbm_pkg;

  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned PTR_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned HIST_DEPTH  = 2 ** PTR_W;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = ((2 * CNT_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic load_pat;
    logic load_gen;
    logic scan_issue;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/sliding_hamming_best_match_unit.sv */
// Pattern byte: next item accepted in the following cycle.
// Genome byte: passes through FINISH when no full window is ready, and through SCAN,
// DRAIN and FINISH when a window is scored; the window is compared one offset per
// cycle through the single read port of the pattern and history memories.
// The result is registered in FINISH after the last genome byte, once the output is free.
// Reset (rst_ni low, asynchronous) clears all counts and flags; memories are not cleared.
module sliding_hamming_best_match_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [shbm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // symbol
  input  logic                              s_axis_tuser,  // kind
  input  logic                              s_axis_tlast,  // last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [shbm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // best_matches, pattern_length
  output logic                              m_axis_tuser   // no_window
);
  import shbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  shbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shbm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_symbol_i     (s_axis_tdata[SYM_W-1:0]),
    .in_last_i       (s_axis_tlast),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_no_window_o (m_axis_tuser)
  );

endmodule

/* hw/rtl/shbm_ctrl.sv */
module shbm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  shbm_pkg::sts_t sts_i,
  output shbm_pkg::cmd_t cmd_o
);
  import shbm_pkg::*;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    last_d          = last_q;
    cmd_o           = '0;
    cmd_o.load_pat  = accept && !in_kind_i;
    cmd_o.load_gen  = accept && in_kind_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_kind_i) begin
          last_d  = in_last_i;
          state_d = sts_i.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

/* hw/rtl/shbm_datapath.sv */
module shbm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [shbm_pkg::SYM_W-1:0]        in_symbol_i,
  input  logic                              in_last_i,
  input  shbm_pkg::cmd_t                    cmd_i,
  output shbm_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [shbm_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                              out_no_window_o
);
  import shbm_pkg::*;

  logic [SYM_W-1:0] pat_mem [PATTERN_MAX];
  logic [SYM_W-1:0] hist_mem [HIST_DEPTH];

  logic [CNT_W-1:0] pcount_q, pcount_d;
  logic             pdone_q, pdone_d;
  logic [CNT_W-1:0] gcount_q, gcount_d;
  logic [CNT_W-1:0] best_q, best_d;
  logic [CNT_W-1:0] match_q, match_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] base_q, base_d;
  logic [PTR_W-1:0] idx_q, idx_d;
  logic             cmp_v_q;
  logic [SYM_W-1:0] pat_rd_q, hist_rd_q;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_best_q, out_plen_q;
  logic             out_none_q;

  logic [CNT_W-1:0] pc_eff, gcount_inc, offset, best_max;
  logic [PTR_W-1:0] hist_addr;
  logic             pat_wr, none;

  assign pc_eff     = pdone_q ? '0 : pcount_q;
  assign pat_wr     = cmd_i.load_pat && (pc_eff < CNT_W'(PATTERN_MAX));
  assign gcount_inc = (gcount_q < CNT_W'(PATTERN_MAX)) ? gcount_q + 1'b1 : gcount_q;
  assign offset     = pcount_q - 1'b1 - CNT_W'(idx_q);
  assign hist_addr  = base_q - offset[PTR_W-1:0];
  assign best_max   = (match_q > best_q) ? match_q : best_q;
  assign none       = (pcount_q == '0) || (gcount_q < pcount_q);

  assign sts_o.need_scan = (pcount_q != '0) && (gcount_inc >= pcount_q);
  assign sts_o.scan_last = (CNT_W'(idx_q) == pcount_q - 1'b1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    pcount_d    = pcount_q;
    pdone_d     = pdone_q;
    gcount_d    = gcount_q;
    best_d      = best_q;
    match_d     = match_q;
    wptr_d      = wptr_q;
    base_d      = base_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load_pat) begin
      pcount_d = pat_wr ? pc_eff + 1'b1 : pc_eff;
      pdone_d  = in_last_i;
      gcount_d = '0;
      best_d   = '0;
    end
    if (cmd_i.load_gen) begin
      pdone_d  = 1'b1;
      gcount_d = gcount_inc;
      wptr_d   = wptr_q + 1'b1;
      base_d   = wptr_q;
      idx_d    = '0;
      match_d  = '0;
    end
    if (cmd_i.scan_issue) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmp_v_q && (pat_rd_q == hist_rd_q)) begin
      match_d = match_q + 1'b1;
    end
    if (cmd_i.finish) begin
      best_d = best_max;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      gcount_d    = '0;
      best_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q    <= '0;
      pdone_q     <= 1'b0;
      gcount_q    <= '0;
      best_q      <= '0;
      match_q     <= '0;
      wptr_q      <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pcount_q    <= pcount_d;
      pdone_q     <= pdone_d;
      gcount_q    <= gcount_d;
      best_q      <= best_d;
      match_q     <= match_d;
      wptr_q      <= wptr_d;
      base_q      <= base_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmd_i.scan_issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_wr) begin
      pat_mem[pc_eff[PTR_W-1:0]] <= in_symbol_i;
    end
    if (cmd_i.scan_issue) begin
      pat_rd_q <= pat_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_gen) begin
      hist_mem[wptr_q] <= in_symbol_i;
    end
    if (cmd_i.scan_issue) begin
      hist_rd_q <= hist_mem[hist_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_best_q <= none ? '0 : best_max;
      out_plen_q <= pcount_q;
      out_none_q <= none;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = OUT_DATA_W'({out_plen_q, out_best_q});
  assign out_no_window_o = out_none_q;

endmodule

/* hw/rtl/shbm_checker.sv */
module shbm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [shbm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input logic                              s_axis_tuser,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [shbm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tuser
);
  import shbm_pkg::*;

  logic [CNT_W-1:0] best, plen;

  assign best = m_axis_tdata[CNT_W-1:0];
  assign plen = m_axis_tdata[2*CNT_W-1:CNT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_window_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> best == '0)
    else $error("no_window with nonzero best count");

  a_best_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> best <= plen)
    else $error("best count exceeds pattern length");

  a_pat_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("pattern transaction took more than one cycle");

endmodule

bind sliding_hamming_best_match_unit shbm_checker u_shbm_checker (.*);
